>>> rtl/ffha_pkg.sv
// ffha_pkg: shared types, codes and constants of the first-fit heap allocator.
// Used by ffha_ctrl, ffha_datapath and first_fit_heap_allocator; depends on nothing.
package ffha_pkg;

    localparam int ADDR_W = 32;

    localparam logic [31:0] ALIGN_BYTES  = 32'd16;
    localparam logic [31:0] ALIGN_MASK   = ALIGN_BYTES - 32'd1;
    localparam logic [31:0] HEADER_BYTES = 32'd32;
    localparam logic [31:0] MIN_BLOCK    = HEADER_BYTES + ALIGN_BYTES;

    // opcodes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_RESIZE  = 2'd2;
    localparam logic [1:0] OP_ADOPT   = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OOM      = 3'd1;
    localparam logic [2:0] ST_NOT_LIVE = 3'd2;
    localparam logic [2:0] ST_REGION   = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ADDR_W-1:0] address;
        logic [31:0]       byte_count;
    } req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [ADDR_W-1:0] result_address;
        logic              moved;
        logic [31:0]       copy_length;
    } rsp_t;

    typedef enum logic [5:0] {
        S_IDLE, S_PREP, S_A_CHK, S_FIT_RD, S_FIT_CMP, S_EL_SCAN, S_TAKE,
        S_RM_RD, S_RM_WR, S_SPLIT, S_SPLIT_END, S_FIN, S_MV_FIN,
        S_IN_RD, S_IN_CMP, S_IN_DEC, S_SH_RD, S_SH_WR,
        S_LV_INIT, S_LV_RD, S_LV_CMP, S_RL_INS, S_RL_END,
        S_RS_CHK, S_GR_RD, S_GR_CMP, S_SNAP_RD, S_SNAP_WR,
        S_MV_INS, S_MV_CHK, S_RST_RD, S_RST_WR, S_AD_CHK, S_AD_END, S_DONE
    } state_t;

    typedef enum logic [5:0] {
        DP_NOP, DP_LOAD, DP_PREP, DP_SET_STATUS, DP_FIT_INIT, DP_FRD_IDX,
        DP_FIT_CMP, DP_EL_STEP, DP_TAKE, DP_RM_RD, DP_RM_WR, DP_RM_END,
        DP_SPLIT_SET, DP_SPLIT_END, DP_FIN, DP_MV_FIN, DP_IN_CMP, DP_IN_DEC,
        DP_SH_RD, DP_SH_WR, DP_SH_PUT, DP_LV_INIT, DP_LV_SKIP, DP_LRD,
        DP_LV_CMP, DP_INS_OLD, DP_LV_CLR, DP_RS_CHK, DP_GR_CMP,
        DP_SNAP_RD, DP_SNAP_WR, DP_RST_INIT, DP_RST_RD, DP_RST_WR,
        DP_INS_ADOPT, DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] code;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       addr_zero;
        logic       addr_low;
        logic       need_ovf;
        logic       is_move;
        logic       adopt_bad;
        logic       idx_end;
        logic       fit_hit;
        logic       in_less;
        logic       nxt;
        logic       prv;
        logic       tbl_full;
        logic       sh_at_idx;
        logic       sh_end;
        logic       rm_last;
        logic       k_end;
        logic       k_valid;
        logic       lv_match;
        logic       need_le_old;
        logic       gr_less;
        logic       gr_hit;
        logic       split_ok;
        logic       ins_ok;
        logic       out_free;
    } dp_flag_t;

endpackage

>>> rtl/first_fit_heap_allocator.sv
// first_fit_heap_allocator: top level of the first-fit heap allocator with coalescing.
// Depends on ffha_pkg, ffha_ctrl and ffha_datapath.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  req     | in        | req_valid/req_stall  | opcode, address, byte_count
//  rsp     | out       | rsp_valid/rsp_stall  | status, result_address, moved, copy_length
//
// One transaction at a time; each free-table entry visited or moved takes a read state
// and a compare or write state (one-port free table with registered read), and each
// live-table entry searched is skipped when invalid, or read and then compared.
// A moving resize also snapshots and, on a full table, restores the free table.
// Reset clears free count, live valid bits, result valid and the sequencer; no sweep.
// The next request is taken as soon as the result sits in the output register,
// even while rsp_stall holds it there.
module first_fit_heap_allocator #(
    parameter int FREE_ENTRIES = 64,
    parameter int LIVE_ENTRIES = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ffha_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ffha_pkg::rsp_t rsp
);

    // command / status between sequencer and datapath
    ffha_pkg::dp_cmd_t  cmd;
    ffha_pkg::dp_flag_t flags;

    ffha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .flags     (flags),
        .cmd       (cmd)
    );

    ffha_datapath #(
        .FREE_ENTRIES (FREE_ENTRIES),
        .LIVE_ENTRIES (LIVE_ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .flags     (flags),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

>>> rtl/ffha_ctrl.sv
// ffha_ctrl: sequencer of the allocator; walks each transaction through table steps.
// Depends on ffha_pkg; drives ffha_datapath through dp_cmd_t and reads dp_flag_t.
module ffha_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  ffha_pkg::dp_flag_t flags,
    output ffha_pkg::dp_cmd_t  cmd
);

    ffha_pkg::state_t state_reg, state_next;
    ffha_pkg::state_t ret_reg, ret_next;     // return of insert / remove
    ffha_pkg::state_t sret_reg, sret_next;   // return of split

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffha_pkg::S_IDLE;
            ret_reg   <= ffha_pkg::S_IDLE;
            sret_reg  <= ffha_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            sret_reg  <= sret_next;
        end
    end

    assign req_stall = (state_reg != ffha_pkg::S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        sret_next  = sret_reg;
        unique case (state_reg)
            ffha_pkg::S_IDLE:
                if (req_valid) state_next = ffha_pkg::S_PREP;
            ffha_pkg::S_PREP:
            begin
                unique case (flags.op)
                    ffha_pkg::OP_ALLOC:   state_next = ffha_pkg::S_A_CHK;
                    ffha_pkg::OP_RELEASE: state_next = flags.addr_zero ? ffha_pkg::S_DONE
                                                                       : ffha_pkg::S_LV_INIT;
                    ffha_pkg::OP_RESIZE:  state_next = flags.addr_zero ? ffha_pkg::S_A_CHK
                                                                       : ffha_pkg::S_LV_INIT;
                    default:              state_next = ffha_pkg::S_AD_CHK;
                endcase
            end
            ffha_pkg::S_A_CHK:
                state_next = flags.need_ovf ? ffha_pkg::S_DONE : ffha_pkg::S_FIT_RD;
            ffha_pkg::S_FIT_RD:
                state_next = flags.idx_end ? ffha_pkg::S_DONE : ffha_pkg::S_FIT_CMP;
            ffha_pkg::S_FIT_CMP:
            begin
                if (!flags.fit_hit)    state_next = ffha_pkg::S_FIT_RD;
                else if (flags.is_move) state_next = ffha_pkg::S_SNAP_RD;
                else                   state_next = ffha_pkg::S_EL_SCAN;
            end
            ffha_pkg::S_EL_SCAN:
            begin
                if (flags.k_end)        state_next = ffha_pkg::S_DONE;
                else if (!flags.k_valid) state_next = ffha_pkg::S_TAKE;
            end
            ffha_pkg::S_TAKE:
            begin
                state_next = ffha_pkg::S_RM_RD;
                ret_next   = ffha_pkg::S_SPLIT;
                sret_next  = flags.is_move ? ffha_pkg::S_MV_INS : ffha_pkg::S_FIN;
            end
            ffha_pkg::S_RM_RD:
                state_next = flags.rm_last ? ret_reg : ffha_pkg::S_RM_WR;
            ffha_pkg::S_RM_WR:
                state_next = ffha_pkg::S_RM_RD;
            ffha_pkg::S_SPLIT:
            begin
                if (flags.split_ok)
                begin
                    state_next = ffha_pkg::S_IN_RD;
                    ret_next   = ffha_pkg::S_SPLIT_END;
                end
                else
                begin
                    state_next = sret_reg;
                end
            end
            ffha_pkg::S_SPLIT_END:
                state_next = sret_reg;
            ffha_pkg::S_FIN, ffha_pkg::S_MV_FIN:
                state_next = ffha_pkg::S_DONE;
            ffha_pkg::S_IN_RD:
                state_next = flags.idx_end ? ffha_pkg::S_IN_DEC : ffha_pkg::S_IN_CMP;
            ffha_pkg::S_IN_CMP:
                state_next = flags.in_less ? ffha_pkg::S_IN_RD : ffha_pkg::S_IN_DEC;
            ffha_pkg::S_IN_DEC:
            begin
                priority if (flags.nxt && flags.prv) state_next = ffha_pkg::S_RM_RD;
                else if (flags.nxt || flags.prv)     state_next = ret_reg;
                else if (flags.tbl_full)             state_next = ret_reg;
                else                                 state_next = ffha_pkg::S_SH_RD;
            end
            ffha_pkg::S_SH_RD:
                state_next = flags.sh_at_idx ? ret_reg : ffha_pkg::S_SH_WR;
            ffha_pkg::S_SH_WR:
                state_next = ffha_pkg::S_SH_RD;
            ffha_pkg::S_LV_INIT:
                state_next = flags.addr_low ? ffha_pkg::S_DONE : ffha_pkg::S_LV_RD;
            ffha_pkg::S_LV_RD:
            begin
                if (flags.k_end)       state_next = ffha_pkg::S_DONE;
                else if (flags.k_valid) state_next = ffha_pkg::S_LV_CMP;
            end
            ffha_pkg::S_LV_CMP:
            begin
                if (!flags.lv_match)                     state_next = ffha_pkg::S_LV_RD;
                else if (flags.op == ffha_pkg::OP_RELEASE) state_next = ffha_pkg::S_RL_INS;
                else                                     state_next = ffha_pkg::S_RS_CHK;
            end
            ffha_pkg::S_RL_INS:
            begin
                state_next = ffha_pkg::S_IN_RD;
                ret_next   = ffha_pkg::S_RL_END;
            end
            ffha_pkg::S_RL_END:
                state_next = ffha_pkg::S_DONE;
            ffha_pkg::S_RS_CHK:
            begin
                if (flags.need_ovf)
                begin
                    state_next = ffha_pkg::S_DONE;
                end
                else if (flags.need_le_old)
                begin
                    state_next = ffha_pkg::S_SPLIT;
                    sret_next  = ffha_pkg::S_FIN;
                end
                else
                begin
                    state_next = ffha_pkg::S_GR_RD;
                end
            end
            ffha_pkg::S_GR_RD:
                state_next = flags.idx_end ? ffha_pkg::S_FIT_RD : ffha_pkg::S_GR_CMP;
            ffha_pkg::S_GR_CMP:
            begin
                priority if (flags.gr_less)
                begin
                    state_next = ffha_pkg::S_GR_RD;
                end
                else if (flags.gr_hit)
                begin
                    state_next = ffha_pkg::S_RM_RD;
                    ret_next   = ffha_pkg::S_SPLIT;
                    sret_next  = ffha_pkg::S_FIN;
                end
                else
                begin
                    state_next = ffha_pkg::S_FIT_RD;
                end
            end
            ffha_pkg::S_SNAP_RD:
                state_next = flags.sh_end ? ffha_pkg::S_TAKE : ffha_pkg::S_SNAP_WR;
            ffha_pkg::S_SNAP_WR:
                state_next = ffha_pkg::S_SNAP_RD;
            ffha_pkg::S_MV_INS:
            begin
                state_next = ffha_pkg::S_IN_RD;
                ret_next   = ffha_pkg::S_MV_CHK;
            end
            ffha_pkg::S_MV_CHK:
                state_next = flags.ins_ok ? ffha_pkg::S_MV_FIN : ffha_pkg::S_RST_RD;
            ffha_pkg::S_RST_RD:
                state_next = flags.sh_end ? ffha_pkg::S_DONE : ffha_pkg::S_RST_WR;
            ffha_pkg::S_RST_WR:
                state_next = ffha_pkg::S_RST_RD;
            ffha_pkg::S_AD_CHK:
            begin
                if (flags.adopt_bad)
                begin
                    state_next = ffha_pkg::S_DONE;
                end
                else
                begin
                    state_next = ffha_pkg::S_IN_RD;
                    ret_next   = ffha_pkg::S_AD_END;
                end
            end
            ffha_pkg::S_AD_END:
                state_next = ffha_pkg::S_DONE;
            ffha_pkg::S_DONE:
                if (flags.out_free) state_next = ffha_pkg::S_IDLE;
            default:
                state_next = ffha_pkg::S_IDLE;
        endcase
    end

    // datapath command
    always_comb
    begin
        cmd.op   = ffha_pkg::DP_NOP;
        cmd.code = ffha_pkg::ST_OK;
        unique case (state_reg)
            ffha_pkg::S_IDLE:
                if (req_valid) cmd.op = ffha_pkg::DP_LOAD;
            ffha_pkg::S_PREP:
                cmd.op = ffha_pkg::DP_PREP;
            ffha_pkg::S_A_CHK:
            begin
                if (flags.need_ovf)
                begin
                    cmd.op   = ffha_pkg::DP_SET_STATUS;
                    cmd.code = ffha_pkg::ST_OOM;
                end
                else
                begin
                    cmd.op = ffha_pkg::DP_FIT_INIT;
                end
            end
            ffha_pkg::S_FIT_RD:
            begin
                if (flags.idx_end)
                begin
                    cmd.op   = ffha_pkg::DP_SET_STATUS;
                    cmd.code = ffha_pkg::ST_OOM;
                end
                else
                begin
                    cmd.op = ffha_pkg::DP_FRD_IDX;
                end
            end
            ffha_pkg::S_FIT_CMP:
                cmd.op = ffha_pkg::DP_FIT_CMP;
            ffha_pkg::S_EL_SCAN:
            begin
                if (flags.k_end)
                begin
                    cmd.op   = ffha_pkg::DP_SET_STATUS;
                    cmd.code = ffha_pkg::ST_FULL;
                end
                else
                begin
                    cmd.op = ffha_pkg::DP_EL_STEP;
                end
            end
            ffha_pkg::S_TAKE:
                cmd.op = ffha_pkg::DP_TAKE;
            ffha_pkg::S_RM_RD:
                cmd.op = flags.rm_last ? ffha_pkg::DP_RM_END : ffha_pkg::DP_RM_RD;
            ffha_pkg::S_RM_WR:
                cmd.op = ffha_pkg::DP_RM_WR;
            ffha_pkg::S_SPLIT:
                if (flags.split_ok) cmd.op = ffha_pkg::DP_SPLIT_SET;
            ffha_pkg::S_SPLIT_END:
                cmd.op = ffha_pkg::DP_SPLIT_END;
            ffha_pkg::S_FIN:
                cmd.op = ffha_pkg::DP_FIN;
            ffha_pkg::S_MV_FIN:
                cmd.op = ffha_pkg::DP_MV_FIN;
            ffha_pkg::S_IN_RD:
                if (!flags.idx_end) cmd.op = ffha_pkg::DP_FRD_IDX;
            ffha_pkg::S_IN_CMP:
                cmd.op = ffha_pkg::DP_IN_CMP;
            ffha_pkg::S_IN_DEC:
                cmd.op = ffha_pkg::DP_IN_DEC;
            ffha_pkg::S_SH_RD:
                cmd.op = flags.sh_at_idx ? ffha_pkg::DP_SH_PUT : ffha_pkg::DP_SH_RD;
            ffha_pkg::S_SH_WR:
                cmd.op = ffha_pkg::DP_SH_WR;
            ffha_pkg::S_LV_INIT:
            begin
                if (flags.addr_low)
                begin
                    cmd.op   = ffha_pkg::DP_SET_STATUS;
                    cmd.code = ffha_pkg::ST_NOT_LIVE;
                end
                else
                begin
                    cmd.op = ffha_pkg::DP_LV_INIT;
                end
            end
            ffha_pkg::S_LV_RD:
            begin
                if (flags.k_end)
                begin
                    cmd.op   = ffha_pkg::DP_SET_STATUS;
                    cmd.code = ffha_pkg::ST_NOT_LIVE;
                end
                else if (flags.k_valid)
                begin
                    cmd.op = ffha_pkg::DP_LRD;
                end
                else
                begin
                    cmd.op = ffha_pkg::DP_LV_SKIP;
                end
            end
            ffha_pkg::S_LV_CMP:
                cmd.op = ffha_pkg::DP_LV_CMP;
            ffha_pkg::S_RL_INS, ffha_pkg::S_MV_INS:
                cmd.op = ffha_pkg::DP_INS_OLD;
            ffha_pkg::S_RL_END:
            begin
                if (flags.ins_ok)
                begin
                    cmd.op = ffha_pkg::DP_LV_CLR;
                end
                else
                begin
                    cmd.op   = ffha_pkg::DP_SET_STATUS;
                    cmd.code = ffha_pkg::ST_FULL;
                end
            end
            ffha_pkg::S_RS_CHK:
            begin
                if (flags.need_ovf)
                begin
                    cmd.op   = ffha_pkg::DP_SET_STATUS;
                    cmd.code = ffha_pkg::ST_OOM;
                end
                else
                begin
                    cmd.op = ffha_pkg::DP_RS_CHK;
                end
            end
            ffha_pkg::S_GR_RD:
                cmd.op = flags.idx_end ? ffha_pkg::DP_FIT_INIT : ffha_pkg::DP_FRD_IDX;
            ffha_pkg::S_GR_CMP:
                cmd.op = ffha_pkg::DP_GR_CMP;
            ffha_pkg::S_SNAP_RD:
                if (!flags.sh_end) cmd.op = ffha_pkg::DP_SNAP_RD;
            ffha_pkg::S_SNAP_WR:
                cmd.op = ffha_pkg::DP_SNAP_WR;
            ffha_pkg::S_MV_CHK:
            begin
                if (!flags.ins_ok)
                begin
                    cmd.op   = ffha_pkg::DP_RST_INIT;
                    cmd.code = ffha_pkg::ST_FULL;
                end
            end
            ffha_pkg::S_RST_RD:
                if (!flags.sh_end) cmd.op = ffha_pkg::DP_RST_RD;
            ffha_pkg::S_RST_WR:
                cmd.op = ffha_pkg::DP_RST_WR;
            ffha_pkg::S_AD_CHK:
            begin
                if (flags.adopt_bad)
                begin
                    cmd.op   = ffha_pkg::DP_SET_STATUS;
                    cmd.code = ffha_pkg::ST_REGION;
                end
                else
                begin
                    cmd.op = ffha_pkg::DP_INS_ADOPT;
                end
            end
            ffha_pkg::S_AD_END:
            begin
                if (!flags.ins_ok)
                begin
                    cmd.op   = ffha_pkg::DP_SET_STATUS;
                    cmd.code = ffha_pkg::ST_FULL;
                end
            end
            ffha_pkg::S_DONE:
                if (flags.out_free) cmd.op = ffha_pkg::DP_OUT;
            default:
                cmd.op = ffha_pkg::DP_NOP;
        endcase
    end

endmodule

>>> rtl/ffha_datapath.sv
// ffha_datapath: free table, snapshot copy, live table, working registers, result register.
// Depends on ffha_pkg; executes one dp_cmd_t per cycle from ffha_ctrl.
module ffha_datapath #(
    parameter int FREE_ENTRIES = 64,
    parameter int LIVE_ENTRIES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ffha_pkg::req_t     req,
    input  ffha_pkg::dp_cmd_t  cmd,
    output ffha_pkg::dp_flag_t flags,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output ffha_pkg::rsp_t     rsp
);

    localparam int FW = $clog2(FREE_ENTRIES);
    localparam int LW = $clog2(LIVE_ENTRIES);
    localparam logic [FW:0] FREE_N = (FW+1)'(FREE_ENTRIES);
    localparam logic [LW:0] LIVE_N = (LW+1)'(LIVE_ENTRIES);

    // tables: entry = {start, length}
    logic [63:0] fmem [FREE_ENTRIES];
    logic [63:0] smem [FREE_ENTRIES];
    logic [63:0] lmem [LIVE_ENTRIES];
    logic [63:0] frd_reg, srd_reg, lrd_reg;

    logic              fm_we, fm_re, sm_we, sm_re, lm_we, lm_re;
    logic [FW-1:0]     fm_wa, fm_ra, sm_a;
    logic [63:0]       fm_wd;
    logic [LW-1:0]     lm_a;

    // control state
    logic [FW:0]             fc_reg;
    logic [LIVE_ENTRIES-1:0] lvalid_reg;
    logic                    out_valid_reg;

    // working registers
    logic [1:0]  op_reg;
    logic [31:0] addr_reg, cnt_reg;
    logic [33:0] need_reg;
    logic        need_ovf_reg, addr_low_reg, adj_ge_reg, adopt_hi_reg;
    logic [31:0] base_b_reg;
    logic [FW:0] idx_reg, sh_reg, fc_save_reg;
    logic [FW-1:0] fit_idx_reg;
    logic [LW:0]   kidx_reg;
    logic [LW-1:0] kslot_reg;
    logic [31:0] ins_s_reg, ins_len_reg;
    logic        ins_ok_reg;
    logic [31:0] prev_s_reg, prev_l_reg, cur_s_reg, cur_l_reg;
    logic [31:0] blk_s_reg;
    logic [32:0] blk_len_reg;
    logic [31:0] old_s_reg, old_len_reg, gr_end_reg;
    logic [2:0]  status_reg;
    logic [31:0] res_reg, copy_reg;
    logic        moved_reg;
    ffha_pkg::rsp_t rsp_reg;

    logic [31:0] frd_s, frd_l;
    logic [FW:0] idx_m1, idx_p1, sh_m1;
    logic [33:0] rnd, need_raw;
    logic [31:0] adj, mv_copy;
    logic [32:0] base;

    assign frd_s = frd_reg[63:32];
    assign frd_l = frd_reg[31:0];
    assign idx_m1 = idx_reg - (FW+1)'(1);
    assign idx_p1 = idx_reg + (FW+1)'(1);
    assign sh_m1  = sh_reg - (FW+1)'(1);

    // size rounding and adopt alignment
    assign rnd      = ({2'b00, cnt_reg} + {2'b00, ffha_pkg::ALIGN_MASK})
                      & ~{2'b00, ffha_pkg::ALIGN_MASK};
    assign need_raw = rnd + {2'b00, ffha_pkg::HEADER_BYTES};
    assign adj      = ((addr_reg & ffha_pkg::ALIGN_MASK) == 32'd0) ? 32'd0
                      : ffha_pkg::ALIGN_BYTES - (addr_reg & ffha_pkg::ALIGN_MASK);
    assign base     = {1'b0, addr_reg} + {1'b0, adj};
    assign mv_copy  = old_len_reg - ffha_pkg::HEADER_BYTES;

    // status to the controller
    always_comb
    begin
        flags.op          = op_reg;
        flags.addr_zero   = (addr_reg == 32'd0);
        flags.addr_low    = addr_low_reg;
        flags.need_ovf    = need_ovf_reg;
        flags.is_move     = (op_reg == ffha_pkg::OP_RESIZE) && (addr_reg != 32'd0);
        flags.adopt_bad   = (addr_reg == 32'd0) || adj_ge_reg || adopt_hi_reg
                            || (ins_len_reg < ffha_pkg::MIN_BLOCK) || (ins_len_reg > ~ins_s_reg);
        flags.idx_end     = (idx_reg >= fc_reg);
        flags.fit_hit     = ({2'b00, frd_l} >= need_reg);
        flags.in_less     = (frd_s < ins_s_reg);
        flags.nxt         = (idx_reg < fc_reg) && (cur_s_reg == ins_s_reg + ins_len_reg);
        flags.prv         = (idx_reg != '0) && (prev_s_reg + prev_l_reg == ins_s_reg);
        flags.tbl_full    = (fc_reg >= FREE_N);
        flags.sh_at_idx   = (sh_reg == idx_reg);
        flags.sh_end      = (sh_reg >= fc_reg);
        flags.rm_last     = (idx_p1 >= fc_reg);
        flags.k_end       = (kidx_reg >= LIVE_N);
        flags.k_valid     = lvalid_reg[kidx_reg[LW-1:0]];
        flags.lv_match    = (lrd_reg[63:32] == base_b_reg);
        flags.need_le_old = (need_reg <= {2'b00, old_len_reg});
        flags.gr_less     = (frd_s < gr_end_reg);
        flags.gr_hit      = (frd_s == gr_end_reg)
                            && (({2'b00, old_len_reg} + {2'b00, frd_l}) >= need_reg);
        flags.split_ok    = ({2'b00, blk_len_reg} >= ({1'b0, need_reg}
                            + {3'b000, ffha_pkg::MIN_BLOCK}));
        flags.ins_ok      = ins_ok_reg;
        flags.out_free    = !out_valid_reg || !rsp_stall;
    end

    // memory port steering
    always_comb
    begin
        fm_we = 1'b0;
        fm_re = 1'b0;
        fm_wa = idx_reg[FW-1:0];
        fm_ra = idx_reg[FW-1:0];
        fm_wd = frd_reg;
        sm_we = 1'b0;
        sm_re = 1'b0;
        sm_a  = sh_reg[FW-1:0];
        lm_we = 1'b0;
        lm_re = 1'b0;
        lm_a  = kidx_reg[LW-1:0];
        unique case (cmd.op)
            ffha_pkg::DP_FRD_IDX: fm_re = 1'b1;
            ffha_pkg::DP_RM_RD:
            begin
                fm_re = 1'b1;
                fm_ra = idx_p1[FW-1:0];
            end
            ffha_pkg::DP_RM_WR: fm_we = 1'b1;
            ffha_pkg::DP_IN_DEC:
            begin
                if (flags.prv)
                begin
                    fm_we = 1'b1;
                    fm_wa = idx_m1[FW-1:0];
                    fm_wd = flags.nxt
                            ? {prev_s_reg, prev_l_reg + ins_len_reg + cur_l_reg}
                            : {prev_s_reg, prev_l_reg + ins_len_reg};
                end
                else if (flags.nxt)
                begin
                    fm_we = 1'b1;
                    fm_wd = {ins_s_reg, cur_l_reg + ins_len_reg};
                end
            end
            ffha_pkg::DP_SH_RD:
            begin
                fm_re = 1'b1;
                fm_ra = sh_m1[FW-1:0];
            end
            ffha_pkg::DP_SH_WR:
            begin
                fm_we = 1'b1;
                fm_wa = sh_reg[FW-1:0];
            end
            ffha_pkg::DP_SH_PUT:
            begin
                fm_we = 1'b1;
                fm_wd = {ins_s_reg, ins_len_reg};
            end
            ffha_pkg::DP_SNAP_RD:
            begin
                fm_re = 1'b1;
                fm_ra = sh_reg[FW-1:0];
            end
            ffha_pkg::DP_SNAP_WR: sm_we = 1'b1;
            ffha_pkg::DP_RST_RD:  sm_re = 1'b1;
            ffha_pkg::DP_RST_WR:
            begin
                fm_we = 1'b1;
                fm_wa = sh_reg[FW-1:0];
                fm_wd = srd_reg;
            end
            ffha_pkg::DP_LRD: lm_re = 1'b1;
            ffha_pkg::DP_FIN, ffha_pkg::DP_MV_FIN:
            begin
                lm_we = 1'b1;
                lm_a  = kslot_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fm_we) fmem[fm_wa] <= fm_wd;
        if (fm_re) frd_reg <= fmem[fm_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sm_we) smem[sm_a] <= frd_reg;
        if (sm_re) srd_reg <= smem[sm_a];
    end

    always_ff @(posedge clk)
    begin
        if (lm_we) lmem[lm_a] <= {blk_s_reg, blk_len_reg[31:0]};
        if (lm_re) lrd_reg <= lmem[lm_a];
    end

    // free count, live valid bits, result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg        <= '0;
            lvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == ffha_pkg::DP_RM_END)
                fc_reg <= fc_reg - (FW+1)'(1);
            else if (cmd.op == ffha_pkg::DP_SH_PUT)
                fc_reg <= fc_reg + (FW+1)'(1);
            else if (cmd.op == ffha_pkg::DP_RST_INIT)
                fc_reg <= fc_save_reg;

            if (cmd.op == ffha_pkg::DP_FIN || cmd.op == ffha_pkg::DP_MV_FIN)
                lvalid_reg[kslot_reg] <= 1'b1;
            else if (cmd.op == ffha_pkg::DP_LV_CLR)
                lvalid_reg[kslot_reg] <= 1'b0;

            if (cmd.op == ffha_pkg::DP_OUT)
                out_valid_reg <= 1'b1;
            else if (!rsp_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            ffha_pkg::DP_LOAD:
            begin
                op_reg     <= req.opcode;
                addr_reg   <= req.address;
                cnt_reg    <= req.byte_count;
                status_reg <= ffha_pkg::ST_OK;
                res_reg    <= 32'd0;
                moved_reg  <= 1'b0;
                copy_reg   <= 32'd0;
            end
            ffha_pkg::DP_PREP:
            begin
                need_reg     <= (need_raw < {2'b00, ffha_pkg::MIN_BLOCK})
                                ? {2'b00, ffha_pkg::MIN_BLOCK} : need_raw;
                need_ovf_reg <= (need_raw > 34'h0FFFFFFFF);
                addr_low_reg <= (addr_reg < ffha_pkg::HEADER_BYTES);
                base_b_reg   <= addr_reg - ffha_pkg::HEADER_BYTES;
                adj_ge_reg   <= (adj >= cnt_reg);
                adopt_hi_reg <= base[32];
                ins_s_reg    <= base[31:0];
                ins_len_reg  <= (cnt_reg - adj) & ~ffha_pkg::ALIGN_MASK;
            end
            ffha_pkg::DP_SET_STATUS:
                status_reg <= cmd.code;
            ffha_pkg::DP_FIT_INIT:
                idx_reg <= '0;
            ffha_pkg::DP_FIT_CMP:
            begin
                if (flags.fit_hit)
                begin
                    fit_idx_reg <= idx_reg[FW-1:0];
                    blk_s_reg   <= frd_s;
                    blk_len_reg <= {1'b0, frd_l};
                    sh_reg      <= '0;
                    fc_save_reg <= fc_reg;
                    kidx_reg    <= '0;
                end
                else
                begin
                    idx_reg <= idx_p1;
                end
            end
            ffha_pkg::DP_EL_STEP:
            begin
                if (flags.k_valid) kidx_reg <= kidx_reg + (LW+1)'(1);
                else               kslot_reg <= kidx_reg[LW-1:0];
            end
            ffha_pkg::DP_TAKE:
                idx_reg <= {1'b0, fit_idx_reg};
            ffha_pkg::DP_RM_WR:
                idx_reg <= idx_p1;
            ffha_pkg::DP_SPLIT_SET:
            begin
                ins_s_reg   <= blk_s_reg + need_reg[31:0];
                ins_len_reg <= blk_len_reg[31:0] - need_reg[31:0];
                idx_reg     <= '0;
                ins_ok_reg  <= 1'b1;
            end
            ffha_pkg::DP_SPLIT_END:
                if (ins_ok_reg) blk_len_reg <= need_reg[32:0];
            ffha_pkg::DP_FIN:
                res_reg <= blk_s_reg + ffha_pkg::HEADER_BYTES;
            ffha_pkg::DP_MV_FIN:
            begin
                res_reg   <= blk_s_reg + ffha_pkg::HEADER_BYTES;
                moved_reg <= 1'b1;
                copy_reg  <= (mv_copy > cnt_reg) ? cnt_reg : mv_copy;
            end
            ffha_pkg::DP_IN_CMP:
            begin
                if (flags.in_less)
                begin
                    prev_s_reg <= frd_s;
                    prev_l_reg <= frd_l;
                    idx_reg    <= idx_p1;
                end
                else
                begin
                    cur_s_reg <= frd_s;
                    cur_l_reg <= frd_l;
                end
            end
            ffha_pkg::DP_IN_DEC:
            begin
                if (!flags.nxt && !flags.prv)
                begin
                    if (flags.tbl_full) ins_ok_reg <= 1'b0;
                    else                sh_reg     <= fc_reg;
                end
            end
            ffha_pkg::DP_SH_WR:
                sh_reg <= sh_m1;
            ffha_pkg::DP_LV_INIT:
                kidx_reg <= '0;
            ffha_pkg::DP_LV_SKIP:
                kidx_reg <= kidx_reg + (LW+1)'(1);
            ffha_pkg::DP_LV_CMP:
            begin
                if (flags.lv_match)
                begin
                    kslot_reg   <= kidx_reg[LW-1:0];
                    old_s_reg   <= lrd_reg[63:32];
                    old_len_reg <= lrd_reg[31:0];
                end
                else
                begin
                    kidx_reg <= kidx_reg + (LW+1)'(1);
                end
            end
            ffha_pkg::DP_INS_OLD:
            begin
                ins_s_reg   <= old_s_reg;
                ins_len_reg <= old_len_reg;
                idx_reg     <= '0;
                ins_ok_reg  <= 1'b1;
            end
            ffha_pkg::DP_RS_CHK:
            begin
                blk_s_reg   <= old_s_reg;
                blk_len_reg <= {1'b0, old_len_reg};
                idx_reg     <= '0;
                gr_end_reg  <= old_s_reg + old_len_reg;
            end
            ffha_pkg::DP_GR_CMP:
            begin
                priority if (flags.gr_less)
                    idx_reg <= idx_p1;
                else if (flags.gr_hit)
                    blk_len_reg <= {1'b0, old_len_reg} + {1'b0, frd_l};
                else
                    idx_reg <= '0;
            end
            ffha_pkg::DP_SNAP_WR:
                sh_reg <= sh_reg + (FW+1)'(1);
            ffha_pkg::DP_RST_INIT:
            begin
                sh_reg     <= '0;
                status_reg <= cmd.code;
            end
            ffha_pkg::DP_RST_WR:
                sh_reg <= sh_reg + (FW+1)'(1);
            ffha_pkg::DP_INS_ADOPT:
            begin
                idx_reg    <= '0;
                ins_ok_reg <= 1'b1;
            end
            ffha_pkg::DP_OUT:
            begin
                rsp_reg.status         <= status_reg;
                rsp_reg.result_address <= res_reg;
                rsp_reg.moved          <= moved_reg;
                rsp_reg.copy_length    <= copy_reg;
            end
            default: ;
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> test/tb_first_fit_heap_allocator.sv
// tb_first_fit_heap_allocator: self-checking testbench for the first-fit heap allocator.
// Depends on ffha_pkg and first_fit_heap_allocator; checks every response against a
// behavioral allocator model kept in step with each accepted request.
module tb_first_fit_heap_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TABLE_DEPTH  = 64;
    localparam logic [63:0] SPACE_MASK   = 64'hFFFF_FFFF;
    localparam logic [63:0] ALIGN        = 64'd16;
    localparam logic [63:0] HDR          = 64'd32;
    localparam logic [63:0] MIN_BLK      = 64'd48;
    localparam int          RANDOM_ITEMS = 1650;
    localparam int          DRAIN_CYCLES = 1500;
    // worst case allows for long table walks per request plus long gaps and stalls
    localparam longint      CYCLE_LIMIT  = 20_000_000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    ffha_pkg::req_t req;
    logic rsp_valid;
    logic rsp_stall;
    ffha_pkg::rsp_t rsp;

    first_fit_heap_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Allocator model: address-ordered free extents and a live-block table.
    // Lengths are whole blocks, header included.
    // ------------------------------------------------------------------
    logic [63:0] ext_base [TABLE_DEPTH];
    logic [63:0] ext_len  [TABLE_DEPTH];
    int          ext_cnt;
    logic [63:0] blk_base [TABLE_DEPTH];
    logic [63:0] blk_len  [TABLE_DEPTH];
    bit          blk_used [TABLE_DEPTH];

    // copy taken before each request so a moving resize can be rolled back
    logic [63:0] ckpt_ext_base [TABLE_DEPTH];
    logic [63:0] ckpt_ext_len  [TABLE_DEPTH];
    int          ckpt_ext_cnt;
    logic [63:0] ckpt_blk_base [TABLE_DEPTH];
    logic [63:0] ckpt_blk_len  [TABLE_DEPTH];
    bit          ckpt_blk_used [TABLE_DEPTH];

    function automatic bit block_need(logic [63:0] bytes, output logic [63:0] need);
        logic [63:0] sz;
        sz = bytes;
        if (sz % ALIGN != 0)
            sz = sz + ALIGN - (sz % ALIGN);
        sz = sz + HDR;
        if (sz < MIN_BLK)
            sz = MIN_BLK;
        need = sz;
        return sz <= SPACE_MASK;
    endfunction

    function automatic void ext_remove(int i);
        if (i >= ext_cnt)
            return;
        for (int j = i; j < ext_cnt - 1; j++)
        begin
            ext_base[j] = ext_base[j+1];
            ext_len[j]  = ext_len[j+1];
        end
        ext_cnt--;
    endfunction

    // insert in address order, merging with the successor first
    function automatic bit ext_insert(logic [63:0] s, logic [63:0] len);
        int p;
        bit nx;
        bit pv;
        p = 0;
        while (p < ext_cnt && ext_base[p] < s)
            p++;
        nx = (p < ext_cnt) && (((s + len) & SPACE_MASK) == ext_base[p]);
        pv = (p > 0) && (((ext_base[p-1] + ext_len[p-1]) & SPACE_MASK) == s);
        if (nx && pv)
        begin
            ext_len[p-1] = (ext_len[p-1] + len + ext_len[p]) & SPACE_MASK;
            ext_remove(p);
        end
        else if (nx)
        begin
            ext_base[p] = s;
            ext_len[p]  = (ext_len[p] + len) & SPACE_MASK;
        end
        else if (pv)
        begin
            ext_len[p-1] = (ext_len[p-1] + len) & SPACE_MASK;
        end
        else
        begin
            if (ext_cnt >= TABLE_DEPTH)
                return 0;
            for (int j = ext_cnt; j > p; j--)
            begin
                ext_base[j] = ext_base[j-1];
                ext_len[j]  = ext_len[j-1];
            end
            ext_base[p] = s;
            ext_len[p]  = len;
            ext_cnt++;
        end
        return 1;
    endfunction

    // give back the tail when it is worth a block of its own
    function automatic void trim_tail(logic [63:0] s, inout logic [63:0] len,
                                      input logic [63:0] need);
        if (len >= need + MIN_BLK && ext_insert((s + need) & SPACE_MASK, len - need))
            len = need;
    endfunction

    function automatic int first_fit(logic [63:0] need);
        for (int i = 0; i < ext_cnt; i++)
            if (ext_len[i] >= need)
                return i;
        return -1;
    endfunction

    function automatic void take_extent(int i, logic [63:0] need,
                                        output logic [63:0] s, output logic [63:0] len);
        s   = ext_base[i];
        len = ext_len[i];
        ext_remove(i);
        trim_tail(s, len, need);
    endfunction

    function automatic int find_block(logic [63:0] addr);
        logic [63:0] b;
        if (addr < HDR)
            return -1;
        b = addr - HDR;
        for (int k = 0; k < TABLE_DEPTH; k++)
            if (blk_used[k] && blk_base[k] == b)
                return k;
        return -1;
    endfunction

    function automatic int free_slot();
        for (int k = 0; k < TABLE_DEPTH; k++)
            if (!blk_used[k])
                return k;
        return -1;
    endfunction

    function automatic void allocate(logic [63:0] cnt, inout logic [2:0] status,
                                     inout logic [63:0] res);
        logic [63:0] need;
        logic [63:0] s;
        logic [63:0] len;
        int i;
        int k;
        i = -1;
        if (block_need(cnt, need))
            i = first_fit(need);
        if (i < 0)
        begin
            status = ffha_pkg::ST_OOM;
            return;
        end
        k = free_slot();
        if (k < 0)
        begin
            status = ffha_pkg::ST_FULL;
            return;
        end
        take_extent(i, need, s, len);
        blk_base[k] = s;
        blk_len[k]  = len;
        blk_used[k] = 1;
        res = s + HDR;
    endfunction

    function automatic ffha_pkg::rsp_t heap_predict(ffha_pkg::req_t r);
        ffha_pkg::rsp_t o;
        logic [2:0]  status;
        logic [63:0] res;
        logic [63:0] copy;
        bit          mv;
        logic [63:0] addr;
        logic [63:0] cnt;
        logic [63:0] need;
        logic [63:0] s;
        logic [63:0] len;
        logic [63:0] ns;
        logic [63:0] nlen;
        logic [63:0] adj;
        logic [63:0] usable;
        int          k;
        int          i;
        int          j;
        status = ffha_pkg::ST_OK;
        res    = 0;
        copy   = 0;
        mv     = 0;
        addr   = {32'd0, r.address};
        cnt    = {32'd0, r.byte_count};
        ckpt_ext_base = ext_base;
        ckpt_ext_len  = ext_len;
        ckpt_ext_cnt  = ext_cnt;
        ckpt_blk_base = blk_base;
        ckpt_blk_len  = blk_len;
        ckpt_blk_used = blk_used;
        case (r.opcode)
            ffha_pkg::OP_ALLOC:
                allocate(cnt, status, res);
            ffha_pkg::OP_RELEASE:
                if (addr != 0)
                begin
                    k = find_block(addr);
                    if (k < 0)
                        status = ffha_pkg::ST_NOT_LIVE;
                    else if (!ext_insert(blk_base[k], blk_len[k]))
                        status = ffha_pkg::ST_FULL;
                    else
                        blk_used[k] = 0;
                end
            ffha_pkg::OP_RESIZE:
            begin
                k = (addr == 0) ? -1 : find_block(addr);
                if (addr == 0)
                    allocate(cnt, status, res);
                else if (k < 0)
                    status = ffha_pkg::ST_NOT_LIVE;
                else if (!block_need(cnt, need))
                    status = ffha_pkg::ST_OOM;
                else
                begin
                    s   = blk_base[k];
                    len = blk_len[k];
                    if (need <= len)
                    begin
                        // shrink in place
                        trim_tail(s, len, need);
                        blk_len[k] = len;
                        res = addr;
                    end
                    else
                    begin
                        j = 0;
                        while (j < ext_cnt && ext_base[j] < ((s + len) & SPACE_MASK))
                            j++;
                        if (j < ext_cnt && ext_base[j] == ((s + len) & SPACE_MASK) &&
                            len + ext_len[j] >= need)
                        begin
                            // grow into the extent right behind the block
                            len = len + ext_len[j];
                            ext_remove(j);
                            trim_tail(s, len, need);
                            blk_len[k] = len;
                            res = addr;
                        end
                        else
                        begin
                            i = first_fit(need);
                            if (i < 0)
                                status = ffha_pkg::ST_OOM;
                            else
                            begin
                                take_extent(i, need, ns, nlen);
                                if (!ext_insert(s, len))
                                begin
                                    // old block has nowhere to go: undo everything
                                    ext_base = ckpt_ext_base;
                                    ext_len  = ckpt_ext_len;
                                    ext_cnt  = ckpt_ext_cnt;
                                    blk_base = ckpt_blk_base;
                                    blk_len  = ckpt_blk_len;
                                    blk_used = ckpt_blk_used;
                                    status   = ffha_pkg::ST_FULL;
                                end
                                else
                                begin
                                    blk_base[k] = ns;
                                    blk_len[k]  = nlen;
                                    res  = ns + HDR;
                                    mv   = 1;
                                    copy = len - HDR;
                                    if (copy > cnt)
                                        copy = cnt;
                                end
                            end
                        end
                    end
                end
            end
            default:
            begin
                adj = (addr % ALIGN == 0) ? 64'd0 : ALIGN - (addr % ALIGN);
                if (addr == 0 || adj >= cnt)
                    status = ffha_pkg::ST_REGION;
                else
                begin
                    usable = cnt - adj;
                    usable = usable - (usable % ALIGN);
                    if (usable < MIN_BLK || addr + adj > SPACE_MASK ||
                        usable > SPACE_MASK - (addr + adj))
                        status = ffha_pkg::ST_REGION;
                    else if (!ext_insert(addr + adj, usable))
                        status = ffha_pkg::ST_FULL;
                end
            end
        endcase
        o.status         = status;
        o.result_address = res[31:0];
        o.moved          = mv;
        o.copy_length    = copy[31:0];
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Queues, counters, pointer pool
    // ------------------------------------------------------------------
    ffha_pkg::req_t pending_req[$];
    ffha_pkg::rsp_t expected_rsp[$];
    logic [31:0]  live_ptrs[$];     // pointers believed live, used to aim requests
    int           mismatches;
    longint       cycles;
    bit           calm;             // no gaps or stalls while set
    bit           req_taken;
    int           req_gap;
    int           stall_left;
    logic [31:0]  region_cursor;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void drop_ptr(logic [31:0] p);
        for (int i = 0; i < live_ptrs.size(); i++)
            if (live_ptrs[i] == p)
            begin
                live_ptrs.delete(i);
                return;
            end
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents requests at the falling edge, holds them while stalled
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_taken)
        begin
            if (req_gap > 0)
            begin
                req_gap   <= req_gap - 1;
                req_valid <= 1'b0;
            end
            else if (pending_req.size() > 0)
            begin
                req       <= pending_req.pop_front();
                req_valid <= 1'b1;
                req_gap   <= pick_gap();
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // response-side backpressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
            if (rst_n && $urandom_range(0, 9) < 3)
                stall_left <= pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at the rising edge, check a response transaction, then
    // run the model on a request transaction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        ffha_pkg::rsp_t exp_r;
        ffha_pkg::rsp_t got_r;
        cycles    <= cycles + 1;
        req_taken <= rst_n && req_valid && !req_stall;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            got_r = rsp;
            if (expected_rsp.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected response: %p", got_r);
            end
            else
            begin
                exp_r = expected_rsp.pop_front();
                if (got_r.status !== exp_r.status ||
                    got_r.result_address !== exp_r.result_address ||
                    got_r.moved !== exp_r.moved ||
                    got_r.copy_length !== exp_r.copy_length)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("response mismatch: expected %p, got %p", exp_r, got_r);
                end
            end
        end
        if (rst_n && req_valid && !req_stall)
        begin
            exp_r = heap_predict(req);
            expected_rsp.push_back(exp_r);
            // keep the pointer pool roughly in line with the live table
            if (exp_r.status == ffha_pkg::ST_OK)
            begin
                if (req.opcode == ffha_pkg::OP_RELEASE)
                    drop_ptr(req.address);
                else if (req.opcode == ffha_pkg::OP_ALLOC ||
                         (req.opcode == ffha_pkg::OP_RESIZE && req.address == 0))
                    live_ptrs.push_back(exp_r.result_address);
                else if (req.opcode == ffha_pkg::OP_RESIZE && exp_r.moved)
                begin
                    drop_ptr(req.address);
                    live_ptrs.push_back(exp_r.result_address);
                end
            end
            if (live_ptrs.size() > 128)
                void'(live_ptrs.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic send(logic [1:0] op, logic [31:0] addr, logic [31:0] cnt);
        ffha_pkg::req_t r;
        r.opcode     = op;
        r.address    = addr;
        r.byte_count = cnt;
        pending_req.push_back(r);
    endtask

    // wait until every queued request has been answered
    task automatic settle();
        while (pending_req.size() > 0 || req_valid || expected_rsp.size() > 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(0, 160);
        if (roll < 90)
            return $urandom_range(0, 4096);
        if (roll < 97)
            return $urandom_range(0, 1 << 20);
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_ptr();
        int roll;
        roll = $urandom_range(0, 99);
        if (live_ptrs.size() > 0 && roll < 85)
            return live_ptrs[$urandom_range(0, live_ptrs.size() - 1)];
        if (roll < 92)
            return $urandom;
        if (roll < 96)
            return $urandom_range(1, 40);
        return region_cursor + 32'd16;
    endfunction

    // modes: 0 mixed, 1 fill, 2 drain, 3 fragment the free table
    task automatic random_item(int mode);
        int          roll;
        logic [31:0] len;
        logic [31:0] base;
        roll = $urandom_range(0, 99);
        case (mode)
            1: roll = (roll < 65) ? 0 : (roll < 75) ? 1 : (roll < 95) ? 2 : 3;
            2: roll = (roll < 15) ? 0 : (roll < 75) ? 1 : (roll < 95) ? 2 : 3;
            3: roll = (roll < 20) ? 0 : (roll < 40) ? 1 : (roll < 50) ? 2 : 3;
            default: roll = (roll < 35) ? 0 : (roll < 65) ? 1 : (roll < 90) ? 2 : 3;
        endcase
        if (roll == 0)
            send(ffha_pkg::OP_ALLOC, $urandom, pick_size());
        else if (roll == 1)
            send(ffha_pkg::OP_RELEASE, pick_ptr(), $urandom);
        else if (roll == 2)
            send(ffha_pkg::OP_RESIZE, ($urandom_range(0, 99) < 8) ? 32'd0 : pick_ptr(),
                 pick_size());
        else if ($urandom_range(0, 9) == 0)
            send(ffha_pkg::OP_ADOPT, $urandom, $urandom);
        else
        begin
            // scattered regions (small in mode 3) fill the free table; touching ones merge
            len  = (mode == 3) ? $urandom_range(40, 90) : $urandom_range(40, 4096);
            base = region_cursor + $urandom_range(0, 15);
            send(ffha_pkg::OP_ADOPT, base, len);
            region_cursor = (region_cursor + len + 32'd32 * $urandom_range(0, 3) + 32'd15)
                            & ~32'hF;
        end
    endtask

    initial
    begin
        int mode;
        clk           = 1'b0;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        rsp_stall     = 1'b0;
        req_taken     = 1'b0;
        req_gap       = 0;
        stall_left    = 0;
        mismatches    = 0;
        cycles        = 0;
        calm          = 1'b0;
        region_cursor = 32'h1100_0000;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty heap, region checks, then a small working heap
        send(ffha_pkg::OP_RELEASE, 32'd0, 32'd0);
        send(ffha_pkg::OP_ALLOC, 32'd0, 32'd16);             // nothing adopted yet
        send(ffha_pkg::OP_ADOPT, 32'd0, 32'h1000);           // base of zero
        send(ffha_pkg::OP_ADOPT, 32'd1, 32'd10);             // alignment eats the region
        send(ffha_pkg::OP_ADOPT, 32'hFFFF_FF00, 32'h200);    // runs past the top
        send(ffha_pkg::OP_ADOPT, 32'h2000_0000, 32'd40);     // below the minimum block
        send(ffha_pkg::OP_ADOPT, 32'h1000_0003, 32'h10_0000);
        send(ffha_pkg::OP_ALLOC, 32'd0, 32'd0);
        send(ffha_pkg::OP_ALLOC, 32'd0, 32'hFFFF_FFFF);      // block size overflows
        send(ffha_pkg::OP_ALLOC, 32'd0, 32'd100);
        send(ffha_pkg::OP_ALLOC, 32'd0, 32'd1);
        send(ffha_pkg::OP_RELEASE, 32'd16, 32'd0);           // below the header
        send(ffha_pkg::OP_RELEASE, 32'hDEAD_BEEF, 32'd0);
        send(ffha_pkg::OP_RESIZE, 32'd0, 32'd64);            // resize of nothing allocates
        settle();
        send(ffha_pkg::OP_RESIZE, live_ptrs[1], 32'd20);     // shrink with split
        send(ffha_pkg::OP_RESIZE, live_ptrs[1], 32'd400);    // must move
        send(ffha_pkg::OP_RESIZE, live_ptrs[2], 32'd1);      // same size
        send(ffha_pkg::OP_RESIZE, live_ptrs[2], 32'hFFFF_FFF0);
        send(ffha_pkg::OP_RELEASE, live_ptrs[0], 32'd0);
        send(ffha_pkg::OP_RELEASE, live_ptrs[0], 32'd0);     // double release
        send(ffha_pkg::OP_RESIZE, live_ptrs[0], 32'd8);      // stale pointer
        send(ffha_pkg::OP_RESIZE, live_ptrs[3], 32'd60);     // new size fits the block, stays in place
        send(ffha_pkg::OP_ADOPT, 32'h1010_0010, 32'h100);    // starts just past the end of the first region
        settle();

        mode = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
            begin
                mode = $urandom_range(0, 3);
                calm = ($urandom_range(0, 3) == 0);
            end
            while (pending_req.size() >= 2)
                @(posedge clk);
            random_item(mode);
        end
        calm = 1'b0;
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_rsp.size() != 0)
            mismatches = mismatches + 1;
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
